### rtl/hack_cpu_instruction_step_assert.svh
// Assertion macros shared by the RTL. Each check is sampled at the rising clock
// edge and is disabled while reset is high.
`ifndef HACK_CPU_INSTRUCTION_STEP_ASSERT_SVH
`define HACK_CPU_INSTRUCTION_STEP_ASSERT_SVH

`ifndef SYNTHESIS

`define HCPU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcpu assertion failed");

`define HCPU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcpu assertion failed");

`else

`define HCPU_ASSERT_SAME(label, clk, rst, ante, cons)

`define HCPU_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/hcpu_pkg.sv
package hcpu_pkg;

   localparam int unsigned DataWords  = 32768;
   localparam int unsigned AddrWidth  = 15;
   localparam int unsigned WordWidth  = 16;
   localparam int unsigned CountWidth = 32;

   localparam logic [AddrWidth-1:0] LastPc  = 15'h7fff;
   localparam logic [WordWidth-1:0] NopWord = 16'h8000;

   typedef enum logic [2:0] {
      FaultNone    = 3'd0,
      FaultIllegal = 3'd1,
      FaultReadA   = 3'd2,
      FaultWriteA  = 3'd3,
      FaultJumpA   = 3'd4,
      FaultPastEnd = 3'd5
   } hcpu_fault_type;

   typedef struct packed {
      logic [2:0]                 fault;
      logic [AddrWidth-1:0]       next_pc;
      logic [WordWidth-1:0]       a_value;
      logic signed [WordWidth-1:0] d_value;
      logic                       mem_written;
      logic [AddrWidth-1:0]       mem_address;
      logic [WordWidth-1:0]       mem_data;
      logic [CountWidth-1:0]      cycles_done;
   } hcpu_rsp_type;

endpackage

### rtl/hcpu_if.sv
interface hcpu_req_if;
   import hcpu_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [WordWidth-1:0] instruction;

   modport source (output valid, output instruction, input ready);
   modport sink (input valid, input instruction, output ready);
endinterface

interface hcpu_rsp_if;
   import hcpu_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [2:0]                  fault;
   logic [AddrWidth-1:0]        next_pc;
   logic [WordWidth-1:0]        a_value;
   logic signed [WordWidth-1:0] d_value;
   logic                        mem_written;
   logic [AddrWidth-1:0]        mem_address;
   logic [WordWidth-1:0]        mem_data;
   logic [CountWidth-1:0]       cycles_done;

   modport source (output valid, output fault, output next_pc, output a_value,
                   output d_value, output mem_written, output mem_address,
                   output mem_data, output cycles_done, input ready);
   modport sink (input valid, input fault, input next_pc, input a_value,
                 input d_value, input mem_written, input mem_address,
                 input mem_data, input cycles_done, output ready);
endinterface

### rtl/hack_cpu_instruction_step.sv
// Hack CPU, one instruction per transfer.
// req_ch carries the instruction word fetched at the pc reported by the last
// result; rsp_ch carries the fault code, pc, A, D, the data memory write of the
// step and the count of completed instructions.
// The instruction is registered into the execute stage together with its data
// memory read, and its result is then registered into the response register.
// Throughput: one instruction per cycle unless rsp_ch stalls. The data memory
// read for an instruction is issued in its transfer cycle with the A value that
// the instruction ahead of it leaves, and a write to the same word in that cycle
// is forwarded, so back-to-back instructions never wait on each other.
// Reset: A, D, pc and the counter clear at once; then the 32768-word data
// memory is cleared one word per cycle, and req_ch.ready stays low until the
// last word is cleared.
// Stall: while a result waits on rsp_ch, one more instruction is taken and held
// in the execute stage; req_ch.ready then drops until the result is taken.
`include "hack_cpu_instruction_step_assert.svh"

module hack_cpu_instruction_step (
   input logic         clock,
   input logic         reset,
   hcpu_req_if.sink    req_ch,
   hcpu_rsp_if.source  rsp_ch
);
   import hcpu_pkg::*;

   logic [WordWidth-1:0] dmem [DataWords];

   logic                  s1_valid_ff;
   logic [WordWidth-1:0]  ins_ff;
   logic [WordWidth-1:0]  reg_a_ff;
   logic [WordWidth-1:0]  reg_d_ff;
   logic [AddrWidth-1:0]  pc_ff;
   logic [CountWidth-1:0] cyc_ff;
   logic                  rsp_valid_ff;
   hcpu_rsp_type          rsp_ff;
   hcpu_rsp_type          rsp_in;
   logic                  clear_ff;
   logic [AddrWidth-1:0]  clr_addr_ff;
   logic [WordWidth-1:0]  rd_data_ff;
   logic                  byp_ff;
   logic [WordWidth-1:0]  byp_data_ff;

   logic                  req_accept;
   logic                  exec_fire;
   logic [WordWidth-1:0]  m_value;
   logic [WordWidth-1:0]  alu_x;
   logic [WordWidth-1:0]  alu_y;
   logic [WordWidth-1:0]  alu_sum;
   logic [WordWidth-1:0]  alu_out;
   logic                  jump_cond;
   hcpu_fault_type        fault_w;
   logic [WordWidth-1:0]  a_new;
   logic [WordWidth-1:0]  d_new;
   logic [AddrWidth-1:0]  pc_new;
   logic [CountWidth-1:0] cyc_new;
   logic                  wr_ok;
   logic                  jumped;
   logic                  halt;
   logic [WordWidth-1:0]  a_in;
   logic [AddrWidth-1:0]  rd_addr;
   logic                  mem_we;
   logic [AddrWidth-1:0]  mem_waddr;
   logic [WordWidth-1:0]  mem_wdata;

   assign req_accept   = req_ch.valid && req_ch.ready;
   assign exec_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !clear_ff && (!s1_valid_ff || exec_fire);
   assign m_value      = byp_ff ? byp_data_ff : rd_data_ff;

   // ALU: zx/nx on D, zy/ny on A or M, add or and, then optional negate.
   always_comb begin
      alu_x = ins_ff[11] ? '0 : reg_d_ff;
      if (ins_ff[10]) begin
         alu_x = ~alu_x;
      end
      alu_y = ins_ff[12] ? m_value : reg_a_ff;
      if (ins_ff[9]) begin
         alu_y = '0;
      end
      if (ins_ff[8]) begin
         alu_y = ~alu_y;
      end
      alu_sum = ins_ff[7] ? (alu_x + alu_y) : (alu_x & alu_y);
      alu_out = ins_ff[6] ? ~alu_sum : alu_sum;
      jump_cond = (alu_out[WordWidth-1] && ins_ff[2])
               || ((alu_out == '0) && ins_ff[1])
               || (!alu_out[WordWidth-1] && (alu_out != '0) && ins_ff[0]);
   end

   always_comb begin
      fault_w = FaultNone;
      a_new   = reg_a_ff;
      d_new   = reg_d_ff;
      pc_new  = pc_ff;
      cyc_new = cyc_ff;
      wr_ok   = 1'b0;
      jumped  = 1'b0;
      halt    = 1'b0;
      if (!ins_ff[15]) begin
         a_new = ins_ff;
      end else if (ins_ff[15:13] == 3'b111) begin
         if (ins_ff[12] && reg_a_ff[15]) begin
            fault_w = FaultReadA;
            halt    = 1'b1;
         end else if (ins_ff[3] && reg_a_ff[15]) begin
            fault_w = FaultWriteA;
            halt    = 1'b1;
         end else begin
            wr_ok = ins_ff[3];
            if (ins_ff[5]) begin
               a_new = alu_out;
            end
            if (ins_ff[4]) begin
               d_new = alu_out;
            end
            // The jump target and its sign check use A after this step's write.
            if (jump_cond) begin
               if (a_new[15]) begin
                  fault_w = FaultJumpA;
                  halt    = 1'b1;
               end else begin
                  pc_new = a_new[AddrWidth-1:0];
                  jumped = 1'b1;
               end
            end
         end
      end else if (ins_ff != NopWord) begin
         fault_w = FaultIllegal;
         halt    = 1'b1;
      end
      if (!halt && !jumped) begin
         if (pc_ff == LastPc) begin
            fault_w = FaultPastEnd;
            halt    = 1'b1;
         end else begin
            pc_new = pc_ff + 1'b1;
         end
      end
      if (!halt) begin
         cyc_new = cyc_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_in.fault       = fault_w;
      rsp_in.next_pc     = pc_new;
      rsp_in.a_value     = a_new;
      rsp_in.d_value     = $signed(d_new);
      rsp_in.mem_written = wr_ok;
      rsp_in.mem_address = wr_ok ? reg_a_ff[AddrWidth-1:0] : '0;
      rsp_in.mem_data    = wr_ok ? alu_out : '0;
      rsp_in.cycles_done = cyc_new;
   end

   // The read for a newly transferred instruction uses the A it will see.
   assign a_in      = exec_fire ? a_new : reg_a_ff;
   assign rd_addr   = a_in[AddrWidth-1:0];
   assign mem_we    = clear_ff || (exec_fire && wr_ok);
   assign mem_waddr = clear_ff ? clr_addr_ff : reg_a_ff[AddrWidth-1:0];
   assign mem_wdata = clear_ff ? '0 : alu_out;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         dmem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff  <= dmem[rd_addr];
         byp_ff      <= mem_we && (mem_waddr == rd_addr);
         byp_data_ff <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         reg_a_ff     <= '0;
         reg_d_ff     <= '0;
         pc_ff        <= '0;
         cyc_ff       <= '0;
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
            ins_ff      <= req_ch.instruction;
         end else if (exec_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (exec_fire) begin
            reg_a_ff     <= a_new;
            reg_d_ff     <= d_new;
            pc_ff        <= pc_new;
            cyc_ff       <= cyc_new;
            rsp_ff       <= rsp_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (clear_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == LastPc) begin
               clear_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.fault       = rsp_ff.fault;
   assign rsp_ch.next_pc     = rsp_ff.next_pc;
   assign rsp_ch.a_value     = rsp_ff.a_value;
   assign rsp_ch.d_value     = rsp_ff.d_value;
   assign rsp_ch.mem_written = rsp_ff.mem_written;
   assign rsp_ch.mem_address = rsp_ff.mem_address;
   assign rsp_ch.mem_data    = rsp_ff.mem_data;
   assign rsp_ch.cycles_done = rsp_ff.cycles_done;

   `HCPU_ASSERT_SAME(a_no_accept_clearing, clock, reset, clear_ff, !req_ch.ready)
   `HCPU_ASSERT_SAME(a_write_only_valid, clock, reset, exec_fire && wr_ok, (fault_w == FaultNone) || (fault_w == FaultJumpA) || (fault_w == FaultPastEnd))
   `HCPU_ASSERT_NEXT(a_fault_holds_count, clock, reset, exec_fire && (fault_w != FaultNone), cyc_ff == $past(cyc_ff))
   `HCPU_ASSERT_NEXT(a_exec_gives_rsp, clock, reset, exec_fire, rsp_valid_ff)

endmodule

### verif/hack_cpu_instruction_step_checker.sv
module hack_cpu_instruction_step_checker (
   input  logic clock,
   input  logic reset,
   hcpu_req_if  req_mon,
   hcpu_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   import hcpu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Bit positions inside a C-instruction word.
   localparam int BitSrcM    = 12;
   localparam int BitZeroX   = 11;
   localparam int BitNotX    = 10;
   localparam int BitZeroY   = 9;
   localparam int BitNotY    = 8;
   localparam int BitAdd     = 7;
   localparam int BitNotOut  = 6;
   localparam int BitDestA   = 5;
   localparam int BitDestD   = 4;
   localparam int BitDestM   = 3;
   localparam int BitJumpLt  = 2;
   localparam int BitJumpEq  = 1;
   localparam int BitJumpGt  = 0;

   logic [WordWidth-1:0]  cpu_a;
   logic [WordWidth-1:0]  cpu_d;
   logic [AddrWidth-1:0]  cpu_pc;
   logic [CountWidth-1:0] cpu_count;
   logic [WordWidth-1:0]  data_mem [DataWords];

   hcpu_rsp_type step_results_q[$];
   int errors;

   function automatic logic [WordWidth-1:0] alu_result(input logic [WordWidth-1:0] word,
                                                       input logic [WordWidth-1:0] x_in,
                                                       input logic [WordWidth-1:0] y_in);
      logic [WordWidth-1:0] x;
      logic [WordWidth-1:0] y;
      logic [WordWidth-1:0] v;
      x = word[BitZeroX] ? '0 : x_in;
      x = word[BitNotX] ? ~x : x;
      y = word[BitZeroY] ? '0 : y_in;
      y = word[BitNotY] ? ~y : y;
      v = word[BitAdd] ? x + y : x & y;
      return word[BitNotOut] ? ~v : v;
   endfunction

   // Executes one instruction against the shadow machine and returns what the
   // block must report for it.
   function automatic hcpu_rsp_type execute_word(input logic [WordWidth-1:0] word);
      hcpu_rsp_type   r;
      hcpu_fault_type code;
      logic [WordWidth-1:0] y;
      logic [WordWidth-1:0] v;
      logic stop;
      logic jumped;
      logic take;
      r = '0;
      code = FaultNone;
      stop = 1'b0;
      jumped = 1'b0;
      if (!word[15]) begin
         cpu_a = word;
      end else if (word[15:13] == 3'b111) begin
         if (word[BitSrcM] && cpu_a[15]) begin
            code = FaultReadA;
            stop = 1'b1;
         end else if (word[BitDestM] && cpu_a[15]) begin
            code = FaultWriteA;
            stop = 1'b1;
         end else begin
            y = word[BitSrcM] ? data_mem[cpu_a[AddrWidth-1:0]] : cpu_a;
            v = alu_result(word, cpu_d, y);
            // The memory address is the A value from before this instruction.
            if (word[BitDestM]) begin
               data_mem[cpu_a[AddrWidth-1:0]] = v;
               r.mem_written = 1'b1;
               r.mem_address = cpu_a[AddrWidth-1:0];
               r.mem_data = v;
            end
            if (word[BitDestA]) cpu_a = v;
            if (word[BitDestD]) cpu_d = v;
            take = (v[15] && word[BitJumpLt]) || ((v == '0) && word[BitJumpEq]) ||
                   (!v[15] && (v != '0) && word[BitJumpGt]);
            if (take) begin
               if (cpu_a[15]) begin
                  code = FaultJumpA;
                  stop = 1'b1;
               end else begin
                  cpu_pc = cpu_a[AddrWidth-1:0];
                  jumped = 1'b1;
               end
            end
         end
      end else if (word != NopWord) begin
         code = FaultIllegal;
         stop = 1'b1;
      end
      if (!stop && !jumped) begin
         if (cpu_pc == LastPc) begin
            code = FaultPastEnd;
            stop = 1'b1;
         end else begin
            cpu_pc = cpu_pc + 1'b1;
         end
      end
      if (!stop) cpu_count = cpu_count + 1'b1;
      r.fault = code;
      r.next_pc = cpu_pc;
      r.a_value = cpu_a;
      r.d_value = cpu_d;
      r.cycles_done = cpu_count;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      hcpu_rsp_type want;
      if (reset) begin
         cpu_a = '0;
         cpu_d = '0;
         cpu_pc = '0;
         cpu_count = '0;
         for (int i = 0; i < DataWords; i++) data_mem[i] = '0;
         step_results_q.delete();
         errors = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            step_results_q.insert(step_results_q.size(),
                                  execute_word(req_mon.instruction));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (step_results_q.size() == 0) begin
               $error("result transfer with no instruction outstanding");
               errors++;
            end else begin
               want = step_results_q.pop_front();
               check_field("fault", 32'(want.fault), 32'(rsp_mon.fault));
               check_field("next_pc", 32'(want.next_pc), 32'(rsp_mon.next_pc));
               check_field("a_value", 32'(want.a_value), 32'(rsp_mon.a_value));
               check_field("d_value", 32'(unsigned'(want.d_value)),
                           32'(unsigned'(rsp_mon.d_value)));
               check_field("mem_written", 32'(want.mem_written), 32'(rsp_mon.mem_written));
               check_field("mem_address", 32'(want.mem_address), 32'(rsp_mon.mem_address));
               check_field("mem_data", 32'(want.mem_data), 32'(rsp_mon.mem_data));
               check_field("cycles_done", want.cycles_done, rsp_mon.cycles_done);
            end
         end
      end
      pending_count <= step_results_q.size();
      fail_count <= errors;
   end

endmodule

### verif/hack_cpu_instruction_step_tb.sv
module hack_cpu_instruction_step_tb;
   import hcpu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomItems = 1650;
   localparam int CycleLimit  = 200000;
   localparam int CalmFirst   = 700;
   localparam int CalmLast    = 1000;
   localparam int SqueezeAt   = 400;
   localparam int SqueezeLen  = 100;

   // ALU function codes (zx nx zy ny f no), Y being A or M.
   localparam logic [5:0] AluZero     = 6'b101010;
   localparam logic [5:0] AluOne      = 6'b111111;
   localparam logic [5:0] AluMinusOne = 6'b111010;
   localparam logic [5:0] AluD        = 6'b001100;
   localparam logic [5:0] AluY        = 6'b110000;
   localparam logic [5:0] AluYPlusOne = 6'b110111;

   localparam logic [2:0] DestNone = 3'b000;
   localparam logic [2:0] DestM    = 3'b001;
   localparam logic [2:0] DestD    = 3'b010;
   localparam logic [2:0] DestA    = 3'b100;

   localparam logic [2:0] JumpNone   = 3'b000;
   localparam logic [2:0] JumpGt     = 3'b001;
   localparam logic [2:0] JumpEq     = 3'b010;
   localparam logic [2:0] JumpLt     = 3'b100;
   localparam logic [2:0] JumpAlways = 3'b111;

   localparam logic SrcA = 1'b0;
   localparam logic SrcM = 1'b1;

   logic clock;
   logic reset;
   int   cycle_count;
   int   items_sent;
   int   fail_count;
   int   pending_count;
   bit   squeezed;

   hcpu_req_if req_ch ();
   hcpu_rsp_if rsp_ch ();

   hack_cpu_instruction_step u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   hack_cpu_instruction_step_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic logic [WordWidth-1:0] c_word(input logic src, input logic [5:0] alu,
                                                   input logic [2:0] dest,
                                                   input logic [2:0] jump);
      return {3'b111, src, alu, dest, jump};
   endfunction

   function automatic logic [WordWidth-1:0] a_word(input logic [AddrWidth-1:0] value);
      return {1'b0, value};
   endfunction

   function automatic logic [WordWidth-1:0] random_word();
      logic [WordWidth-1:0] w;
      int pick;
      w = 16'($urandom());
      pick = $urandom_range(99);
      if (pick < 35) begin
         // Half the A-instructions use low addresses so that memory words get reused.
         if ($urandom_range(99) < 50) w = a_word(15'($urandom_range(15)));
         else if ($urandom_range(99) < 15) w = a_word(LastPc);
         else w[15] = 1'b0;
      end else if (pick < 85) begin
         w[15:13] = 3'b111;
      end else if (pick < 90) begin
         w = NopWord;
      end else begin
         w[15] = 1'b1;
         w[14:13] = 2'($urandom_range(2));
      end
      return w;
   endfunction

   task automatic send_instruction(input logic [WordWidth-1:0] word);
      while (!(items_sent >= CalmFirst && items_sent < CalmLast) &&
             $urandom_range(99) < 21) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.instruction <= word;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Result side: random back-pressure, one long hold-off while the sender keeps
   // offering, and a stretch with no stalls at all.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!squeezed && items_sent >= SqueezeAt) begin
            squeezed = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (SqueezeLen) @(posedge clock);
         end else begin
            rsp_ch.ready <= (items_sent >= CalmFirst && items_sent < CalmLast) ||
                            ($urandom_range(99) >= 21);
            @(posedge clock);
         end
      end
   end

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [WordWidth-1:0] directed[$];
      cycle_count = 0;
      items_sent = 0;
      squeezed = 1'b0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.instruction <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      directed = {
         a_word(LastPc),
         a_word('0),
         c_word(SrcA, AluOne, DestD, JumpNone),
         c_word(SrcA, AluD, DestM, JumpNone),
         c_word(SrcM, AluYPlusOne, DestD, JumpNone),
         a_word(LastPc),
         c_word(SrcA, AluMinusOne, DestM, JumpNone),
         // Negative result jumps to the last pc, which is allowed.
         c_word(SrcM, AluY, DestD, JumpLt),
         // Falling off the last pc while making A negative.
         c_word(SrcA, AluD, DestA, JumpNone),
         c_word(SrcM, AluY, DestD, JumpNone),
         c_word(SrcA, AluZero, DestM, JumpNone),
         c_word(SrcA, AluZero, DestNone, JumpAlways),
         // D is written before the jump with a negative A faults.
         c_word(SrcA, AluOne, DestD, JumpGt),
         NopWord,
         16'hA5A5,
         16'hC000,
         16'h8001,
         16'hDFFF,
         a_word(15'd3),
         c_word(SrcA, AluZero, DestNone, JumpAlways),
         c_word(SrcA, AluD, DestNone, JumpEq),
         16'hFFFF,
         16'h0000,
         NopWord
      };
      foreach (directed[i]) send_instruction(directed[i]);
      for (int n = 0; n < RandomItems; n++) send_instruction(random_word());
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
